FILE: rtl/core/sfme_pkg.sv
// ----------------------------------------------------------------------------
// sfme_pkg
// Types, codes and constants shared by the stream filter/map engine.
// ----------------------------------------------------------------------------
package sfme_pkg;

    localparam int unsigned MAX_COUNT_DEF = 4096;
    localparam int unsigned SLOT_MAX      = 4095;
    localparam int unsigned SLOT_W        = 12;
    localparam int unsigned DATA_W        = 32;

    // trial division constants: 3 is tested alone, then pairs 6k-1 / 6k+1
    localparam int unsigned TRIAL_THREE   = 3;
    localparam int unsigned FIRST_PAIR    = 5;
    localparam int unsigned PAIR_STEP     = 6;
    localparam int unsigned PAIR_GAP      = 2;

    localparam int unsigned TRIAL_W       = 17;   // divisors stay below 2^17
    localparam int unsigned DSQ_W         = 33;   // square of the divisor base

    // register indexes
    localparam logic REG_FILTER_MODE = 1'b0;
    localparam logic REG_MAP_MODE    = 1'b1;

    // filter codes
    localparam logic [1:0] FILT_POSITIVE = 2'd0;
    localparam logic [1:0] FILT_EVEN     = 2'd1;
    localparam logic [1:0] FILT_PRIME    = 2'd2;

    // map codes
    localparam logic [1:0] MAP_ADD_ONE   = 2'd0;
    localparam logic [1:0] MAP_IDENTITY  = 2'd1;
    localparam logic [1:0] MAP_SQUARE    = 2'd2;
    localparam logic [1:0] MAP_POPCOUNT  = 2'd3;

    // result kinds
    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               final_item;
    } sfme_in_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] payload;
        logic [11:0]        slot;
        logic               run_end;
    } sfme_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_NEXT,
        ST_MAP,
        ST_POP,
        ST_OUT_ELEM,
        ST_OUT_CNT
    } sfme_state_t;

endpackage

FILE: rtl/core/stream_filter_map_engine_core.sv
// ----------------------------------------------------------------------------
// stream_filter_map_engine_core
// Filters signed samples (positive, even or prime) and maps the kept ones.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sample plus final_item flag per transfer. s_ready is high
//   only in idle: one sample in flight, the next taken in the cycle after it retires.
//   m_ channel: a kept sample gives one element result (kind 0) carrying the
//   mapped value and its slot; a final sample then gives a count result
//   (kind 1) and clears the kept count. run_end marks the last result of a
//   sample. A sample neither kept nor final gives nothing.
//   APB port: filter_mode at 0x0, map_mode at 0x4, low two bits kept.
// Processing per sample (accept to first result offered):
//   positive / even filter: ST_MAP then ST_OUT_ELEM, plus ST_POP for popcount mapping.
//   prime filter: each trial divisor takes a full pass of the one-bit-per-cycle
//   remainder unit; up to roughly 15,500 divisors for values near 2^31.
// Reset (aresetn low, synchronous): idle, mode registers and count cleared.
// A stalled receiver simply holds the engine in its output state; the
// result stays on m_data unchanged until the transfer completes.
// ----------------------------------------------------------------------------
module stream_filter_map_engine_core #(
    parameter int unsigned MAX_COUNT = sfme_pkg::MAX_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_valid,
    output logic                s_ready,
    input  sfme_pkg::sfme_in_t  s_data,
    // result stream
    output logic                m_valid,
    input  logic                m_ready,
    output sfme_pkg::sfme_out_t m_data,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sfme_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

    // ---------------------------------------------------------------- state
    sfme_state_t         state_reg, state_next;
    sfme_in_t            in_reg, in_next;
    logic [1:0]          filter_mode_reg, filter_mode_next;
    logic [1:0]          map_mode_reg, map_mode_next;
    logic [CNT_W-1:0]    kept_reg, kept_next;

    // shared remainder unit: restoring, one dividend bit per cycle
    logic [TRIAL_W-1:0]  trial_reg, trial_next;   // current divisor
    logic [TRIAL_W-1:0]  rem_reg, rem_next;       // partial remainder
    logic [DATA_W-1:0]   dvd_reg, dvd_next;       // dividend / popcount shifter
    logic [4:0]          cnt_reg, cnt_next;       // bit counter

    // trial division sequencing
    logic [TRIAL_W-1:0]  d_reg, d_next;           // pair base 6k-1
    logic [DSQ_W-1:0]    dsq_reg, dsq_next;       // d squared
    logic                three_reg, three_next;   // testing divisor 3
    logic                hi_reg, hi_next;         // testing 6k+1

    logic [DATA_W-1:0]   result_reg, result_next;
    logic [5:0]          pop_reg, pop_next;

    // ------------------------------------------------------- datapath terms
    logic [TRIAL_W:0]    rem_shift;
    logic                rem_ge;
    logic [5:0]          pop_sum;
    logic [DSQ_W-1:0]    dsq_step;
    logic [DATA_W-1:0]   kept_wide;
    logic                cfg_write;
    logic                in_prime_small;

    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, trial_reg};
    assign pop_sum   = pop_reg + 6'(dvd_reg[DATA_W-1]);
    // (d+6)^2 = d^2 + 12d + 36
    assign dsq_step  = dsq_reg + DSQ_W'({d_reg, 3'b000})
                     + DSQ_W'({d_reg, 2'b00})
                     + DSQ_W'(PAIR_STEP * PAIR_STEP);
    assign kept_wide = DATA_W'(kept_reg);
    assign in_prime_small = (s_data.sample <= 32'sd3);

    // ------------------------------------------------------ APB config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_FILTER_MODE: prdata = {30'd0, filter_mode_reg};
            REG_MAP_MODE:    prdata = {30'd0, map_mode_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        filter_mode_next = filter_mode_reg;
        map_mode_next    = map_mode_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_FILTER_MODE: filter_mode_next = pwdata[1:0];
                REG_MAP_MODE:    map_mode_next    = pwdata[1:0];
                default:         ;
            endcase
        end
    end

    // ----------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_data.final_item ? ST_OUT_CNT : ST_IDLE;
                    case (filter_mode_reg)
                        FILT_POSITIVE: begin
                            if (s_data.sample > 32'sd0) state_next = ST_MAP;
                        end
                        FILT_EVEN: begin
                            if (!s_data.sample[0]) state_next = ST_MAP;
                        end
                        FILT_PRIME: begin
                            if (s_data.sample <= 32'sd1) begin
                                // not prime: keep fail path
                            end else if (in_prime_small) begin
                                state_next = ST_MAP;
                            end else if (s_data.sample[0]) begin
                                state_next = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (cnt_reg == 5'd0) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (rem_reg == '0) begin
                    state_next = in_reg.final_item ? ST_OUT_CNT : ST_IDLE;
                end else if (!three_reg && !hi_reg) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (dsq_reg > DSQ_W'(unsigned'(in_reg.sample))) state_next = ST_MAP;
                else                                           state_next = ST_DIV;
            end
            ST_MAP: begin
                if (map_mode_reg == MAP_POPCOUNT && in_reg.sample > 32'sd0) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_OUT_ELEM;
                end
            end
            ST_POP: begin
                if (cnt_reg == 5'd0) state_next = ST_OUT_ELEM;
            end
            ST_OUT_ELEM: begin
                if (m_ready) state_next = in_reg.final_item ? ST_OUT_CNT : ST_IDLE;
            end
            ST_OUT_CNT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------- datapath / outputs
    always_comb begin
        in_next     = in_reg;
        kept_next   = kept_reg;
        trial_next  = trial_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        cnt_next    = cnt_reg;
        d_next      = d_reg;
        dsq_next    = dsq_reg;
        three_next  = three_reg;
        hi_next     = hi_reg;
        result_next = result_reg;
        pop_next    = pop_reg;

        s_ready = 1'b0;
        m_valid = 1'b0;
        m_data  = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_data;
                    // set up the divide-by-3 test; harmless for other modes
                    trial_next = TRIAL_W'(TRIAL_THREE);
                    three_next = 1'b1;
                    hi_next    = 1'b0;
                    d_next     = TRIAL_W'(FIRST_PAIR);
                    dsq_next   = DSQ_W'(FIRST_PAIR * FIRST_PAIR);
                    dvd_next   = s_data.sample;
                    rem_next   = '0;
                    cnt_next   = 5'd31;
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? TRIAL_W'(rem_shift - {1'b0, trial_reg})
                                  : rem_shift[TRIAL_W-1:0];
                dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
            end
            ST_CHECK: begin
                dvd_next = in_reg.sample;
                rem_next = '0;
                cnt_next = 5'd31;
                if (!three_reg && !hi_reg) begin
                    trial_next = d_reg + TRIAL_W'(PAIR_GAP);
                    hi_next    = 1'b1;
                end else begin
                    three_next = 1'b0;
                    if (hi_reg) begin
                        hi_next  = 1'b0;
                        d_next   = d_reg + TRIAL_W'(PAIR_STEP);
                        dsq_next = dsq_step;
                    end
                end
            end
            ST_NEXT: begin
                trial_next = d_reg;
            end
            ST_MAP: begin
                dvd_next = in_reg.sample;
                cnt_next = 5'd31;
                pop_next = '0;
                case (map_mode_reg)
                    MAP_ADD_ONE:  result_next = in_reg.sample + 32'd1;
                    MAP_IDENTITY: result_next = in_reg.sample;
                    MAP_SQUARE:   result_next = unsigned'(in_reg.sample)
                                              * unsigned'(in_reg.sample);
                    MAP_POPCOUNT: result_next = '0;
                    default:      result_next = '0;
                endcase
            end
            ST_POP: begin
                pop_next    = pop_sum;
                result_next = DATA_W'(pop_sum);
                dvd_next    = {dvd_reg[DATA_W-2:0], 1'b0};
                cnt_next    = cnt_reg - 5'd1;
            end
            ST_OUT_ELEM: begin
                m_valid        = 1'b1;
                m_data.kind    = KIND_ELEMENT;
                m_data.payload = result_reg;
                m_data.slot    = (kept_wide > DATA_W'(SLOT_MAX)) ? SLOT_W'(SLOT_MAX)
                                                                 : kept_wide[SLOT_W-1:0];
                m_data.run_end = !in_reg.final_item;
                if (m_ready && kept_reg < CNT_W'(MAX_COUNT)) begin
                    kept_next = kept_reg + CNT_W'(1);
                end
            end
            ST_OUT_CNT: begin
                m_valid        = 1'b1;
                m_data.kind    = KIND_COUNT;
                m_data.payload = kept_wide;
                m_data.slot    = '0;
                m_data.run_end = 1'b1;
                if (m_ready) kept_next = '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            filter_mode_reg <= FILT_POSITIVE;
            map_mode_reg    <= MAP_ADD_ONE;
            kept_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            filter_mode_reg <= filter_mode_next;
            map_mode_reg    <= map_mode_next;
            kept_reg        <= kept_next;
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        trial_reg  <= trial_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        cnt_reg    <= cnt_next;
        d_reg      <= d_next;
        dsq_reg    <= dsq_next;
        three_reg  <= three_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
        pop_reg    <= pop_next;
    end

endmodule
